@@ sv/mou_pkg.sv @@
package mou_pkg;

   // Command codes of an input item.
   localparam logic [1:0] CMD_READ_REG  = 2'd0;
   localparam logic [1:0] CMD_WRITE_REG = 2'd1;
   localparam logic [1:0] CMD_READ_RM   = 2'd2;
   localparam logic [1:0] CMD_WRITE_RM  = 2'd3;

   // ModRM field values with a special meaning.
   localparam logic [1:0] MOD_REGISTER = 2'b11;
   localparam logic [1:0] MOD_NO_DISP  = 2'b00;
   localparam logic [2:0] RM_DIRECT    = 3'b110;

   // Segment override codes; the unused codes mean no override.
   localparam logic [2:0] OVR_NONE = 3'd0;
   localparam logic [2:0] OVR_SS   = 3'd1;
   localparam logic [2:0] OVR_DS   = 3'd2;
   localparam logic [2:0] OVR_ES   = 3'd3;
   localparam logic [2:0] OVR_CS   = 3'd4;

   // General register numbers.
   localparam logic [2:0] REG_BX = 3'd3;
   localparam logic [2:0] REG_BP = 3'd5;
   localparam logic [2:0] REG_SI = 3'd6;
   localparam logic [2:0] REG_DI = 3'd7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CODE_SEG  = 2'd0;
   localparam logic [1:0] CSR_DATA_SEG  = 2'd1;
   localparam logic [1:0] CSR_EXTRA_SEG = 2'd2;
   localparam logic [1:0] CSR_STACK_SEG = 2'd3;

   typedef struct packed {
      logic load;
      logic resolve;
      logic finish;
   } mou_cmd_type;

endpackage

@@ sv/modrm_operand_unit.sv @@
// Channel   Handshake              Payload
// request   start high, busy low   req_command .. req_write_value
// result    rsp_valid, one cycle   rsp_read_data, rsp_is_memory, rsp_physical_address
// csr       psel, penable, pwrite  paddr, pwdata, prdata (pready always high)
//
// An item passes three steps: capture, resolve (register access and effective
// address), then the segment add; the result strobe follows in the next cycle,
// when a new item may already be accepted; no new item is taken while busy.
// Items are paced by the controller's three-step sequence.
// Reset clears the general registers and segment bases to zero.
// The receiver cannot stall; each result is shown for exactly one cycle.
module modrm_operand_unit
   import mou_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic               req_byte_op,
   input  logic [2:0]         req_reg_code,
   input  logic [1:0]         req_mode_bits,
   input  logic [2:0]         req_rm_bits,
   input  logic signed [15:0] req_displacement,
   input  logic [2:0]         req_segment_override,
   input  logic [15:0]        req_write_value,
   output logic               rsp_valid,
   output logic [15:0]        rsp_read_data,
   output logic               rsp_is_memory,
   output logic [20:0]        rsp_physical_address,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   mou_cmd_type cmd;
   logic        csr_we;
   logic [15:0] csr_rdata;

   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;
   assign prdata = {16'd0, csr_rdata};

   mou_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   mou_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_command          (req_command),
      .req_byte_op          (req_byte_op),
      .req_reg_code         (req_reg_code),
      .req_mode_bits        (req_mode_bits),
      .req_rm_bits          (req_rm_bits),
      .req_displacement     (req_displacement),
      .req_segment_override (req_segment_override),
      .req_write_value      (req_write_value),
      .csr_we               (csr_we),
      .csr_index            (paddr[3:2]),
      .csr_wdata            (pwdata[15:0]),
      .csr_rdata            (csr_rdata),
      .rsp_read_data        (rsp_read_data),
      .rsp_is_memory        (rsp_is_memory),
      .rsp_physical_address (rsp_physical_address)
   );

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid)
      else $error("result strobe did not follow an accepted item");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequence is still running");

   a_reg_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_memory |-> rsp_physical_address == 21'd0)
      else $error("register operand carries an address");

   a_mem_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_memory |-> rsp_read_data == 16'd0)
      else $error("memory operand carries read data");

endmodule

@@ sv/mou_ctrl.sv @@
module mou_ctrl
   import mou_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output mou_cmd_type cmd,
   output logic        rsp_valid
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RESOLVE = 2'd1;
   localparam logic [1:0] ST_FINISH  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == ST_FINISH);
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = start && (state_ff == ST_IDLE);
   assign cmd.resolve = (state_ff == ST_RESOLVE);
   assign cmd.finish  = (state_ff == ST_FINISH);
   assign rsp_valid   = valid_ff;

endmodule

@@ sv/mou_dpath.sv @@
module mou_dpath
   import mou_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mou_cmd_type        cmd,
   input  logic [1:0]         req_command,
   input  logic               req_byte_op,
   input  logic [2:0]         req_reg_code,
   input  logic [1:0]         req_mode_bits,
   input  logic [2:0]         req_rm_bits,
   input  logic signed [15:0] req_displacement,
   input  logic [2:0]         req_segment_override,
   input  logic [15:0]        req_write_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic [15:0]        csr_rdata,
   output logic [15:0]        rsp_read_data,
   output logic               rsp_is_memory,
   output logic [20:0]        rsp_physical_address
);

   // Captured item.
   logic [1:0]  command_ff;
   logic        byte_op_ff;
   logic [2:0]  reg_code_ff;
   logic [1:0]  mode_ff;
   logic [2:0]  rm_ff;
   logic [15:0] disp_ff;
   logic [2:0]  override_ff;
   logic [15:0] wval_ff;

   // Segment bases.
   logic [15:0] cs_ff;
   logic [15:0] ds_ff;
   logic [15:0] es_ff;
   logic [15:0] ss_ff;

   logic [15:0] regfile_ff [8];
   logic [15:0] regfile_in [8];

   // Intermediate results between the resolve and finish steps.
   logic [15:0] ea_ff;
   logic [15:0] ea_in;
   logic [15:0] seg_ff;
   logic [15:0] seg_in;
   logic [15:0] rdata_ff;
   logic [15:0] rdata_in;
   logic        mem_ff;
   logic        mem_in;

   logic [15:0] out_rdata_ff;
   logic        out_mem_ff;
   logic [20:0] out_addr_ff;

   logic [2:0]  code;
   logic [1:0]  byte_reg;
   logic        reg_operand;
   logic        do_read;
   logic        do_write;
   logic [15:0] base;
   logic [15:0] index;

   always_comb begin
      code        = command_ff[1] ? rm_ff : reg_code_ff;
      byte_reg    = code[1:0];
      reg_operand = !command_ff[1] || (mode_ff == MOD_REGISTER);
      mem_in      = !reg_operand;
      do_read     = reg_operand && ((command_ff == CMD_READ_REG) ||
                                    (command_ff == CMD_READ_RM));
      do_write    = reg_operand && ((command_ff == CMD_WRITE_REG) ||
                                    (command_ff == CMD_WRITE_RM));

      rdata_in = 16'd0;
      if (do_read) begin
         if (!byte_op_ff) rdata_in = regfile_ff[code];
         else if (code[2]) rdata_in = {8'd0, regfile_ff[{1'b0, byte_reg}][15:8]};
         else rdata_in = {8'd0, regfile_ff[{1'b0, byte_reg}][7:0]};
      end

      regfile_in = regfile_ff;
      if (do_write) begin
         if (!byte_op_ff) regfile_in[code] = wval_ff;
         else if (code[2]) regfile_in[{1'b0, byte_reg}][15:8] = wval_ff[7:0];
         else regfile_in[{1'b0, byte_reg}][7:0] = wval_ff[7:0];
      end

      base   = 16'd0;
      index  = 16'd0;
      seg_in = ds_ff;
      case (rm_ff)
         3'd0: begin base = regfile_ff[REG_BX]; index = regfile_ff[REG_SI]; end
         3'd1: begin base = regfile_ff[REG_BX]; index = regfile_ff[REG_DI]; end
         3'd2: begin
            base = regfile_ff[REG_BP]; index = regfile_ff[REG_SI]; seg_in = ss_ff;
         end
         3'd3: begin
            base = regfile_ff[REG_BP]; index = regfile_ff[REG_DI]; seg_in = ss_ff;
         end
         3'd4: index = regfile_ff[REG_SI];
         3'd5: index = regfile_ff[REG_DI];
         3'd6: begin
            // Mod zero with this rm is direct addressing: displacement alone.
            if (mode_ff != MOD_NO_DISP) begin
               base   = regfile_ff[REG_BP];
               seg_in = ss_ff;
            end
         end
         default: base = regfile_ff[REG_BX];
      endcase
      ea_in = base + index + disp_ff;

      case (override_ff)
         OVR_SS:  seg_in = ss_ff;
         OVR_DS:  seg_in = ds_ff;
         OVR_ES:  seg_in = es_ff;
         OVR_CS:  seg_in = cs_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= 16'd0;
         ds_ff <= 16'd0;
         es_ff <= 16'd0;
         ss_ff <= 16'd0;
         for (int i = 0; i < 8; i++) regfile_ff[i] <= 16'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CODE_SEG:  cs_ff <= csr_wdata;
               CSR_DATA_SEG:  ds_ff <= csr_wdata;
               CSR_EXTRA_SEG: es_ff <= csr_wdata;
               CSR_STACK_SEG: ss_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.resolve) regfile_ff <= regfile_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff  <= req_command;
         byte_op_ff  <= req_byte_op;
         reg_code_ff <= req_reg_code;
         mode_ff     <= req_mode_bits;
         rm_ff       <= req_rm_bits;
         disp_ff     <= $unsigned(req_displacement);
         override_ff <= req_segment_override;
         wval_ff     <= req_write_value;
      end
      if (cmd.resolve) begin
         ea_ff    <= ea_in;
         seg_ff   <= seg_in;
         rdata_ff <= rdata_in;
         mem_ff   <= mem_in;
      end
      if (cmd.finish) begin
         out_rdata_ff <= rdata_ff;
         out_mem_ff   <= mem_ff;
         out_addr_ff  <= mem_ff ? ({1'b0, seg_ff, 4'd0} + {5'd0, ea_ff}) : 21'd0;
      end
   end

   always_comb begin
      case (csr_index)
         CSR_CODE_SEG:  csr_rdata = cs_ff;
         CSR_DATA_SEG:  csr_rdata = ds_ff;
         CSR_EXTRA_SEG: csr_rdata = es_ff;
         CSR_STACK_SEG: csr_rdata = ss_ff;
         default:       csr_rdata = 16'd0;
      endcase
   end

   assign rsp_read_data        = out_rdata_ff;
   assign rsp_is_memory        = out_mem_ff;
   assign rsp_physical_address = out_addr_ff;

endmodule
